FILE: sv/sacl_pkg.sv
// ---------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants for the LFU write-through cache.
// ---------------------------------------------------------------------------
package sacl_pkg;

    localparam int MAX_SET_BITS   = 4;
    localparam int MAX_BLOCK_BITS = 4;
    localparam int MAX_WAYS       = 4;
    localparam int ADDR_BITS      = 12;

    localparam logic [1:0] MODE_READ    = 2'd0;
    localparam logic [1:0] MODE_WRITE   = 2'd1;
    localparam logic [1:0] MODE_PRELOAD = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    localparam logic [1:0] REG_SET_BITS   = 2'd0;
    localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
    localparam logic [1:0] REG_WAYS       = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic capture;     // latch the accepted transaction
        logic mem_wr_in;   // write the input byte to backing memory
        logic lookup;      // evaluate tags and pick the way
        logic hit_update;  // apply hit bookkeeping
        logic fill_start;  // claim the victim line, reset fill counter
        logic fill_rd;     // issue a backing memory read for the fill
        logic fill_wr;     // store the returned byte into the line
        logic rd_line;     // read the line byte at the offset
        logic load_out;    // load the result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clearing;
        logic is_preload;
        logic is_idle_mode;
        logic is_hit;
        logic is_write;
        logic fill_last;
    } t_status;

endpackage

FILE: sv/sacl_ram.sv
// ---------------------------------------------------------------------------
// sacl_ram
// Generic single-port RAM with registered read.
// ---------------------------------------------------------------------------
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sv/sacl_ctrl.sv
// ---------------------------------------------------------------------------
// sacl_ctrl
// Sequencer: lookup, block fill and result handoff.
// ---------------------------------------------------------------------------
module sacl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  sacl_pkg::t_status i_status,
    output sacl_pkg::t_cmd    o_cmd
);
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_LOOK   = 8'b0000_0010,
        S_FSTART = 8'b0000_0100,
        S_FRD    = 8'b0000_1000,
        S_FWR    = 8'b0001_0000,
        S_LREAD  = 8'b0010_0000,
        S_LDATA  = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;

    // out register frees when taken; new item waits for idle, end of clearing and a free slot
    assign o_in_ready  = (r_state == S_IDLE) && !i_status.clearing
                         && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.mem_wr_in = i_status.is_write || i_status.is_preload;
                o_cmd.lookup    = 1'b1;
                if (i_status.is_preload || i_status.is_idle_mode) begin
                    n_state = S_OUT;
                end else if (i_status.is_hit) begin
                    o_cmd.hit_update = 1'b1;
                    n_state = i_status.is_write ? S_OUT : S_LREAD;
                end else begin
                    n_state = S_FSTART;
                end
            end
            S_FSTART: begin
                o_cmd.fill_start = 1'b1;
                n_state = S_FRD;
            end
            S_FRD: begin
                o_cmd.fill_rd = 1'b1;
                n_state = S_FWR;
            end
            S_FWR: begin
                o_cmd.fill_wr = 1'b1;
                n_state = i_status.fill_last ? S_LREAD : S_FRD;
            end
            S_LREAD: begin
                o_cmd.rd_line = 1'b1;
                n_state = S_LDATA;
            end
            S_LDATA: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

FILE: sv/sacl_dp.sv
// ---------------------------------------------------------------------------
// sacl_dp
// Datapath: tag store, LFU counts, line and backing memories, result.
// ---------------------------------------------------------------------------
module sacl_dp #(
    parameter int MAX_SET_BITS   = sacl_pkg::MAX_SET_BITS,
    parameter int MAX_BLOCK_BITS = sacl_pkg::MAX_BLOCK_BITS,
    parameter int MAX_WAYS       = sacl_pkg::MAX_WAYS,
    parameter int ADDR_BITS      = sacl_pkg::ADDR_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [2:0]           i_cfg_data,
    input  logic [1:0]           i_mode,
    input  logic [ADDR_BITS-1:0] i_address,
    input  logic [7:0]           i_write_data,
    input  sacl_pkg::t_cmd       i_cmd,
    output sacl_pkg::t_status    o_status,
    output logic [7:0]           o_read_data,
    output logic                 o_hit
);
    localparam int NSETS  = 1 << MAX_SET_BITS;
    localparam int NLINES = NSETS * MAX_WAYS;
    localparam int LSIZE  = 1 << MAX_BLOCK_BITS;
    localparam int LW     = (NLINES > 1) ? $clog2(NLINES) : 1;
    localparam int WW     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int SW     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int OW     = (MAX_BLOCK_BITS > 0) ? MAX_BLOCK_BITS : 1;
    localparam int BW     = $clog2(LSIZE + 1);
    localparam int CW     = $clog2(MAX_WAYS + 1);
    localparam int TAGW   = 12;
    localparam int LBW    = $clog2(NLINES * LSIZE);
    localparam int TEW    = 1 + 8 + TAGW;   // valid, use count, tag
    localparam int NCLR   = NLINES * LSIZE;

    logic [2:0] r_set_bits, r_block_bits, r_ways;
    logic [1:0] r_mode;
    logic [ADDR_BITS-1:0] r_addr;
    logic [7:0] r_wdata;

    logic [WW-1:0] r_way;
    logic          r_hit;
    logic [BW-1:0] r_fcnt;
    logic [7:0]    r_res;
    logic          r_hit_out;

    logic           r_clr_busy;
    logic [LBW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= 3'd2;
            r_block_bits <= 3'd2;
            r_ways       <= 3'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sacl_pkg::REG_SET_BITS:   r_set_bits   <= i_cfg_data;
                sacl_pkg::REG_BLOCK_BITS: r_block_bits <= i_cfg_data;
                sacl_pkg::REG_WAYS:       r_ways       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clearing pass after reset: one line byte (and one tag entry) per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + LBW'(1);
            if (r_clr_addr == LBW'(NCLR - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // effective geometry
    logic [3:0] w_sb, w_bb;
    logic [CW-1:0] w_ways;
    always_comb begin
        w_sb = (int'(r_set_bits) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : {1'b0, r_set_bits};
        w_bb = (int'(r_block_bits) > MAX_BLOCK_BITS) ? 4'(MAX_BLOCK_BITS)
                                                     : {1'b0, r_block_bits};
        if (r_ways == 3'd0) w_ways = CW'(1);
        else if (int'(r_ways) > MAX_WAYS) w_ways = CW'(MAX_WAYS);
        else w_ways = CW'(r_ways);
    end

    logic [ADDR_BITS-1:0] w_off_mask, w_set_mask, w_start;
    logic [OW-1:0] w_off;
    logic [SW-1:0] w_set, w_in_set;
    logic [TAGW-1:0] w_tag;
    logic [ADDR_BITS-1:0] w_tag_full;
    always_comb begin
        w_off_mask = ~({ADDR_BITS{1'b1}} << w_bb);
        w_set_mask = ~({ADDR_BITS{1'b1}} << w_sb);
        w_off      = OW'(r_addr & w_off_mask);
        w_set      = SW'((r_addr >> w_bb) & w_set_mask);
        w_in_set   = SW'((i_address >> w_bb) & w_set_mask);
        w_tag_full = r_addr >> (w_bb + w_sb);
        w_tag      = TAGW'(w_tag_full);
        w_start    = r_addr & ~w_off_mask;
    end

    function automatic logic [LW-1:0] line_of(input logic [SW-1:0] s, input logic [WW-1:0] w);
        line_of = LW'(int'(s) * MAX_WAYS + int'(w));
    endfunction

    // tag store: one RAM per way, addressed by set; read at capture so the
    // entries of the set are ready in the lookup cycle
    logic [SW-1:0]   w_te_addr;
    logic            w_te_we    [MAX_WAYS];
    logic [TEW-1:0]  w_te_wdata [MAX_WAYS];
    logic [TEW-1:0]  w_te_rdata [MAX_WAYS];
    logic            w_tv       [MAX_WAYS];
    logic [7:0]      w_tc       [MAX_WAYS];
    logic [TAGW-1:0] w_tt       [MAX_WAYS];
    logic [WW-1:0]   w_hit_way;

    assign w_te_addr = r_clr_busy ? SW'(r_clr_addr) : (i_cmd.capture ? w_in_set : w_set);

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            w_tv[w]       = w_te_rdata[w][TEW-1];
            w_tc[w]       = w_te_rdata[w][TAGW +: 8];
            w_tt[w]       = w_te_rdata[w][TAGW-1:0];
            w_te_we[w]    = 1'b0;
            w_te_wdata[w] = '0;
            if (r_clr_busy) begin
                w_te_we[w] = 1'b1;
            end else if (i_cmd.fill_start && r_way == WW'(w)) begin
                w_te_we[w]    = 1'b1;
                w_te_wdata[w] = {1'b1, 8'd1, w_tag};
            end else if (i_cmd.hit_update && r_mode == sacl_pkg::MODE_READ
                         && w_hit_way == WW'(w)) begin
                w_te_we[w]    = 1'b1;
                w_te_wdata[w] = {1'b1, w_tc[w] + 8'd1, w_tt[w]};
            end
        end
    end

    for (genvar g = 0; g < MAX_WAYS; g++) begin : g_tag_ram
        sacl_ram #(.WIDTH(TEW), .DEPTH(1 << SW)) u_tag_ram (
            .i_clk(i_clk), .i_we(w_te_we[g]), .i_addr(w_te_addr),
            .i_wdata(w_te_wdata[g]), .o_rdata(w_te_rdata[g])
        );
    end

    // tag compare and LFU victim choice across the ways of the set
    logic          w_hit;
    logic [WW-1:0] w_vic;
    logic          w_found_inv;
    logic [7:0]    w_best;
    always_comb begin
        w_hit = 1'b0; w_hit_way = '0; w_found_inv = 1'b0; w_vic = '0;
        w_best = w_tc[0];
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (CW'(w) < w_ways) begin
                if (!w_hit && w_tv[w] && w_tt[w] == w_tag) begin
                    w_hit = 1'b1; w_hit_way = WW'(w);
                end
            end
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (CW'(w) < w_ways && !w_found_inv && !w_tv[w]) begin
                w_found_inv = 1'b1; w_vic = WW'(w);
            end
        end
        if (!w_found_inv) begin
            for (int w = 1; w < MAX_WAYS; w++) begin
                if (CW'(w) < w_ways && w_tc[w] < w_best) begin
                    w_best = w_tc[w]; w_vic = WW'(w);
                end
            end
        end
    end

    logic [LW-1:0] w_line;
    assign w_line = line_of(w_set, r_way);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_mode;
            r_addr  <= i_address;
            r_wdata <= i_write_data;
        end
        if (i_cmd.lookup) begin
            r_hit <= w_hit;
            r_way <= w_hit ? w_hit_way : w_vic;
        end
        if (i_cmd.fill_start) begin
            r_fcnt <= '0;
        end else if (i_cmd.fill_wr) begin
            r_fcnt <= r_fcnt + BW'(1);
        end
    end

    // line byte store: zeroed by the clearing pass after reset
    logic [LBW-1:0] w_lb_addr;
    logic [OW-1:0]  w_lb_off;
    logic           w_lb_we;
    logic [7:0]     w_lb_wdata, w_lb_rdata;
    logic [ADDR_BITS-1:0] w_mem_addr;
    logic           w_mem_we;
    logic [7:0]     w_mem_rdata;

    always_comb begin
        w_lb_off   = w_off;
        w_lb_we    = 1'b0;
        w_lb_wdata = r_wdata;
        if (i_cmd.fill_wr) begin
            w_lb_off = OW'(r_fcnt);
            w_lb_we  = 1'b1;
            // write miss: the stored byte at the offset is the new data
            w_lb_wdata = (r_mode == sacl_pkg::MODE_WRITE && OW'(r_fcnt) == w_off)
                         ? r_wdata : w_mem_rdata;
        end else if (i_cmd.hit_update && r_mode == sacl_pkg::MODE_WRITE) begin
            w_lb_we = 1'b1;
        end
        w_lb_addr  = LBW'({(i_cmd.hit_update ? line_of(w_set, w_hit_way) : w_line), w_lb_off});
        if (r_clr_busy) begin
            w_lb_we    = 1'b1;
            w_lb_wdata = 8'd0;
            w_lb_addr  = r_clr_addr;
        end
        w_mem_addr = i_cmd.fill_rd ? (w_start | ADDR_BITS'(r_fcnt)) : r_addr;
        w_mem_we   = i_cmd.mem_wr_in;
    end

    sacl_ram #(.WIDTH(8), .DEPTH(NLINES * LSIZE)) u_line_ram (
        .i_clk(i_clk), .i_we(w_lb_we), .i_addr(w_lb_addr),
        .i_wdata(w_lb_wdata), .o_rdata(w_lb_rdata)
    );

    sacl_ram #(.WIDTH(8), .DEPTH(1 << ADDR_BITS)) u_mem_ram (
        .i_clk(i_clk), .i_we(w_mem_we), .i_addr(w_mem_addr),
        .i_wdata(r_wdata), .o_rdata(w_mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (r_mode == sacl_pkg::MODE_PRELOAD || r_mode == sacl_pkg::MODE_WRITE) begin
                r_res     <= r_wdata;
                r_hit_out <= (r_mode == sacl_pkg::MODE_WRITE) && r_hit;
            end else if (r_mode == sacl_pkg::MODE_READ) begin
                r_res     <= w_lb_rdata;
                r_hit_out <= r_hit;
            end else begin
                r_res     <= 8'd0;
                r_hit_out <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.clearing     = r_clr_busy;
        o_status.is_preload   = (r_mode == sacl_pkg::MODE_PRELOAD);
        o_status.is_idle_mode = (r_mode == sacl_pkg::MODE_UNUSED);
        o_status.is_hit       = w_hit;
        o_status.is_write     = (r_mode == sacl_pkg::MODE_WRITE);
        o_status.fill_last    = (r_fcnt + BW'(1)) == (BW'(1) << w_bb);
    end

    assign o_read_data = r_res;
    assign o_hit       = r_hit_out;
endmodule

FILE: sv/set_assoc_cache_lfu_write_through.sv
// Flow: one transaction at a time; preload, unused mode and write hits skip
// the line read, and a miss first fills the block, reading each byte from the
// single-port backing memory RAM and then writing it into the line.
// Reset: i_rst_n synchronous, loads the geometry registers, then a clearing
// pass zeroes line bytes, valid bits, counts and tags, o_ready low.
// ---------------------------------------------------------------------------
// set_assoc_cache_lfu_write_through
// Set-associative byte cache with LFU replacement over a write-through
// backing memory, built as a sequencer plus datapath.
// ---------------------------------------------------------------------------
module set_assoc_cache_lfu_write_through #(
    parameter int MAX_SET_BITS   = sacl_pkg::MAX_SET_BITS,
    parameter int MAX_BLOCK_BITS = sacl_pkg::MAX_BLOCK_BITS,
    parameter int MAX_WAYS       = sacl_pkg::MAX_WAYS,
    parameter int ADDR_BITS      = sacl_pkg::ADDR_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration transactions
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [2:0]           i_cfg_data,
    // access transactions
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_mode,
    input  logic [ADDR_BITS-1:0] i_address,
    input  logic [7:0]           i_write_data,
    // results
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_read_data,
    output logic                 o_hit
);
    sacl_pkg::t_cmd    w_cmd;
    sacl_pkg::t_status w_status;

    // register writes must arrive only while idle, a rule left to the user; take them at once
    assign o_cfg_ready = 1'b1;

    sacl_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .o_in_ready(o_ready),
        .o_out_valid(o_valid), .i_out_ready(i_ready),
        .i_status(w_status), .o_cmd(w_cmd)
    );

    sacl_dp #(
        .MAX_SET_BITS(MAX_SET_BITS), .MAX_BLOCK_BITS(MAX_BLOCK_BITS),
        .MAX_WAYS(MAX_WAYS), .ADDR_BITS(ADDR_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_valid), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_mode(i_mode), .i_address(i_address), .i_write_data(i_write_data),
        .i_cmd(w_cmd), .o_status(w_status),
        .o_read_data(o_read_data), .o_hit(o_hit)
    );
endmodule

FILE: sv/sacl_checker.sv
// ---------------------------------------------------------------------------
// sacl_checker
// Port-level checks on the cache, bound to the top level.
// ---------------------------------------------------------------------------
module sacl_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_read_data,
    input logic       o_hit
);
    // a result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_read_data) && $stable(o_hit))
        else $error("result changed while stalled");

    // an accepted transaction does not present its result at once
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !o_valid |=> !o_valid)
        else $error("result too early");

    // one transaction in flight: no accept right after an accept
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second transaction accepted while busy");
endmodule

bind set_assoc_cache_lfu_write_through sacl_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_read_data(o_read_data), .o_hit(o_hit)
);

FILE: verif/set_assoc_cache_lfu_write_through_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// set_assoc_cache_lfu_write_through_tb
// Self-checking bench for the LFU write-through cache: a shadow cache and
// backing memory predict every result, which the checker compares in order.
// ---------------------------------------------------------------------------
module set_assoc_cache_lfu_write_through_tb;
    import sacl_pkg::*;

    localparam int NUM_LINES  = (1 << MAX_SET_BITS) * MAX_WAYS;
    localparam int LINE_BYTES = 1 << MAX_BLOCK_BITS;
    localparam int MEM_BYTES  = 1 << ADDR_BITS;
    localparam int STALL_LIMIT = 6000;
    localparam logic [1:0] REG_NONE    = 2'd3;

    typedef struct packed {
        logic [7:0] read_data;
        logic       hit;
    } t_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [1:0]           i_cfg_index = '0;
    logic [2:0]           i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [1:0]           i_mode = '0;
    logic [ADDR_BITS-1:0] i_address = '0;
    logic [7:0]           i_write_data = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [7:0]           o_read_data;
    logic                 o_hit;

    set_assoc_cache_lfu_write_through dut (.*);

    always #4 i_clk = ~i_clk;

    // shadow geometry registers and cache contents
    logic [2:0]           sh_set_bits;
    logic [2:0]           sh_block_bits;
    logic [2:0]           sh_ways;
    logic                 sh_valid [NUM_LINES];
    logic [7:0]           sh_count [NUM_LINES];
    logic [11:0]          sh_tag   [NUM_LINES];
    logic [7:0]           sh_bytes [NUM_LINES*LINE_BYTES];
    logic [7:0]           mem_image [MEM_BYTES];
    bit                   mem_written [MEM_BYTES];

    t_result              pending_results [$];
    int                   err_count = 0;
    int                   idle_cycles = 0;
    int                   sent_count = 0;
    logic [ADDR_BITS-1:0] hot_addr [8];

    // effective geometry after saturation
    function automatic int eff_sb();
        return (sh_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(sh_set_bits);
    endfunction
    function automatic int eff_bb();
        return (sh_block_bits > MAX_BLOCK_BITS) ? MAX_BLOCK_BITS : int'(sh_block_bits);
    endfunction
    function automatic int eff_ways();
        if (sh_ways == 0) return 1;
        return (sh_ways > MAX_WAYS) ? MAX_WAYS : int'(sh_ways);
    endfunction

    function automatic int set_base(logic [ADDR_BITS-1:0] addr);
        return int'((addr >> eff_bb()) & ((1 << eff_sb()) - 1)) * MAX_WAYS;
    endfunction
    function automatic logic [11:0] addr_tag(logic [ADDR_BITS-1:0] addr);
        return 12'((addr >> (eff_bb() + eff_sb())) & 12'hFFF);
    endfunction

    // matching way index, or -1 on a miss
    function automatic int find_way(logic [ADDR_BITS-1:0] addr);
        int base;
        base = set_base(addr);
        for (int w = 0; w < eff_ways(); w++)
            if (sh_valid[base+w] && sh_tag[base+w] == addr_tag(addr)) return w;
        return -1;
    endfunction

    // compute the result of one access and update the shadow state
    function automatic t_result cache_access(logic [1:0] mode,
                                             logic [ADDR_BITS-1:0] addr,
                                             logic [7:0] data);
        t_result r;
        int base, way, line, bsize, offset, start;
        r = '0;
        bsize  = 1 << eff_bb();
        offset = int'(addr) & (bsize - 1);
        start  = int'(addr) - offset;
        base   = set_base(addr);
        if (mode == MODE_PRELOAD) begin
            mem_image[addr] = data;
            mem_written[addr] = 1'b1;
            r.read_data = data;
            return r;
        end
        if (mode == MODE_UNUSED) return r;
        if (mode == MODE_WRITE) begin
            mem_image[addr] = data;
            mem_written[addr] = 1'b1;
        end
        way = find_way(addr);
        if (way >= 0) begin
            line = base + way;
            if (mode == MODE_READ) begin
                sh_count[line] = sh_count[line] + 8'd1;
            end else begin
                sh_bytes[line*LINE_BYTES+offset] = data;
            end
            r.read_data = sh_bytes[line*LINE_BYTES+offset];
            r.hit = 1'b1;
            return r;
        end
        // victim: first invalid way, else lowest count, lowest index on ties
        way = -1;
        for (int w = 0; w < eff_ways(); w++)
            if (way < 0 && !sh_valid[base+w]) way = w;
        if (way < 0) begin
            way = 0;
            for (int w = 1; w < eff_ways(); w++)
                if (sh_count[base+w] < sh_count[base+way]) way = w;
        end
        line = base + way;
        sh_valid[line] = 1'b1;
        sh_tag[line]   = addr_tag(addr);
        sh_count[line] = 8'd1;
        for (int j = 0; j < bsize; j++)
            sh_bytes[line*LINE_BYTES+j] = mem_image[start+j];
        if (mode == MODE_WRITE) sh_bytes[line*LINE_BYTES+offset] = data;
        r.read_data = sh_bytes[line*LINE_BYTES+offset];
        return r;
    endfunction

    // random gap length: mostly none or short, a few long
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // send one transaction on the access channel; entered at a falling edge
    task automatic send_txn(logic [1:0] mode, logic [ADDR_BITS-1:0] addr,
                            logic [7:0] data);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_mode = mode;
        i_address = addr;
        i_write_data = data;
        i_valid = 1'b1;
        // hold the payload until the transaction is taken
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(cache_access(mode, addr, data));
        sent_count++;
        @(negedge i_clk);
    endtask

    // send an access, first preloading any never-written byte a miss would fill
    task automatic issue_access(logic [1:0] mode, logic [ADDR_BITS-1:0] addr,
                                logic [7:0] data);
        int bsize, start;
        bsize = 1 << eff_bb();
        start = int'(addr) & ~(bsize - 1);
        if ((mode == MODE_READ || mode == MODE_WRITE) && find_way(addr) < 0) begin
            for (int j = 0; j < bsize; j++)
                if (!mem_written[start+j])
                    send_txn(MODE_PRELOAD, ADDR_BITS'(start + j), 8'($urandom));
        end
        send_txn(mode, addr, data);
    endtask

    // drain outstanding results, then write one register while idle
    task automatic write_reg(logic [1:0] idx, logic [2:0] val);
        i_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_index = idx;
        i_cfg_data = val;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_SET_BITS:   sh_set_bits = val;
            REG_BLOCK_BITS: sh_block_bits = val;
            REG_WAYS:       sh_ways = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_geometry(logic [2:0] sb, logic [2:0] bb, logic [2:0] ways);
        write_reg(REG_SET_BITS, sb);
        write_reg(REG_BLOCK_BITS, bb);
        write_reg(REG_WAYS, ways);
    endtask

    // random access: hot addresses give hits, full-range ones cover all bits
    task automatic random_access();
        int p;
        logic [1:0] mode;
        logic [ADDR_BITS-1:0] addr;
        p = $urandom_range(0, 99);
        mode = (p < 45) ? MODE_READ : (p < 80) ? MODE_WRITE :
               (p < 95) ? MODE_PRELOAD : MODE_UNUSED;
        if ($urandom_range(0, 99) < 5) hot_addr[$urandom_range(0, 7)] = ADDR_BITS'($urandom);
        if ($urandom_range(0, 99) < 60) addr = hot_addr[$urandom_range(0, 7)];
        else addr = ADDR_BITS'($urandom_range(0, MEM_BYTES - 1));
        issue_access(mode, addr, 8'($urandom));
    endtask

    // random traffic until about n transactions, preloads included, are sent
    task automatic run_random(int n);
        int stop;
        stop = sent_count + n;
        while (sent_count < stop) random_access();
    endtask

    // extremes of the fields, every mode, hits and misses of both kinds
    task automatic test_directed();
        issue_access(MODE_READ, 12'h000, 8'h00);
        issue_access(MODE_READ, 12'h001, 8'hFF);
        issue_access(MODE_WRITE, 12'h002, 8'hFF);
        issue_access(MODE_READ, 12'h002, 8'h00);
        issue_access(MODE_WRITE, 12'hFFF, 8'h00);
        issue_access(MODE_WRITE, 12'hFFF, 8'hAA);
        issue_access(MODE_READ, 12'hFFC, 8'h55);
        send_txn(MODE_PRELOAD, 12'h003, 8'h5A);
        issue_access(MODE_READ, 12'h003, 8'h00);
        send_txn(MODE_UNUSED, 12'hFFF, 8'hFF);
        // same set, five tags: LFU eviction in a four-way set
        for (int t = 1; t <= 5; t++)
            issue_access(MODE_READ, ADDR_BITS'(t << 4), 8'h00);
        issue_access(MODE_READ, 12'h010, 8'h00);
        issue_access(MODE_READ, 12'h000, 8'h00);
    endtask

    // hammer one line past 255 hits so its count wraps and it loses LFU
    task automatic test_count_wrap();
        set_geometry(3'd1, 3'd1, 3'd2);
        issue_access(MODE_READ, 12'h100, 8'h00);
        issue_access(MODE_READ, 12'h200, 8'h00);
        for (int k = 0; k < 256; k++) issue_access(MODE_READ, 12'h100, 8'h00);
        issue_access(MODE_READ, 12'h300, 8'h00);
        issue_access(MODE_READ, 12'h100, 8'h00);
    endtask

    // random traffic under a range of geometries, extremes included
    task automatic test_geometries();
        set_geometry(3'd0, 3'd0, 3'd1);
        run_random(140);
        set_geometry(3'd4, 3'd4, 3'd4);
        run_random(140);
        write_reg(REG_NONE, 3'd5);
        set_geometry(3'd7, 3'd7, 3'd0);
        run_random(140);
        set_geometry(3'd5, 3'd6, 3'd7);
        run_random(140);
        // geometry change with lines kept
        set_geometry(3'd3, 3'd1, 3'd3);
        run_random(140);
        set_geometry(3'd2, 3'd2, 3'd4);
        run_random(140);
    endtask

    // result channel backpressure, changed at the falling edge
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < 30) begin
            stall_left <= gap_len();
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                if (err_count < 10)
                    $display("unexpected result: read_data=%0h hit=%0b", o_read_data, o_hit);
                err_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_read_data !== exp_r.read_data || o_hit !== exp_r.hit) begin
                    if (err_count < 10)
                        $display("mismatch: read_data exp %0h got %0h, hit exp %0b got %0b",
                                 exp_r.read_data, o_read_data, exp_r.hit, o_hit);
                    err_count++;
                end
            end
        end
    end

    // watchdog: count cycles with no transaction on any channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)
            || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        sh_set_bits = 3'd2;
        sh_block_bits = 3'd2;
        sh_ways = 3'd4;
        for (int i = 0; i < NUM_LINES; i++) begin
            sh_valid[i] = 1'b0;
            sh_count[i] = '0;
            sh_tag[i] = '0;
        end
        foreach (sh_bytes[i]) sh_bytes[i] = '0;
        foreach (mem_image[i]) begin
            mem_image[i] = '0;
            mem_written[i] = 1'b0;
        end
        foreach (hot_addr[i]) hot_addr[i] = ADDR_BITS'($urandom);
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_count_wrap();
        test_geometries();

        // drain and let the pipeline settle
        i_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (err_count == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
